// ----- sv/wtsp_pkg.sv -----
// shared types and constants of the world-to-screen projection pipeline
package wtsp_pkg;

  localparam int QUO_W = 39;
  localparam int PIX_LIMIT = 1000000;

  localparam logic [3:0] CFG_X_ROW_FIRST   = 4'd0;
  localparam logic [3:0] CFG_X_ROW_SECOND  = 4'd1;
  localparam logic [3:0] CFG_Y_ROW_FIRST   = 4'd2;
  localparam logic [3:0] CFG_Y_ROW_SECOND  = 4'd3;
  localparam logic [3:0] CFG_W_ROW_FIRST   = 4'd4;
  localparam logic [3:0] CFG_W_ROW_SECOND  = 4'd5;
  localparam logic [3:0] CFG_SCREEN_WIDTH  = 4'd6;
  localparam logic [3:0] CFG_SCREEN_HEIGHT = 4'd7;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_BEHIND   = 2'd1,
    ST_UNSTABLE = 2'd2,
    ST_RANGE    = 2'd3
  } status_t;

  // one lane of the restoring divider
  typedef struct packed {
    logic [62:0]      rem;
    logic [6:0]       nbits;
    logic [QUO_W-1:0] quo;
    logic             neg;
  } div_lane_t;

  typedef struct packed {
    logic [62:0] den;
    div_lane_t   lx;
    div_lane_t   ly;
    status_t     st;
  } div_word_t;

endpackage

// ----- sv/wtsp_dot.sv -----
// pipelined row dot product with sticky signed 64-bit overflow detect
module wtsp_dot #(
  parameter int COORD_FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic [3:0]         en,
  input  logic [63:0]        row_first,
  input  logic [63:0]        row_second,
  input  logic signed [31:0] px,
  input  logic signed [31:0] py,
  input  logic signed [31:0] pz,
  output logic signed [63:0] sum,
  output logic               ov
);
  import wtsp_pkg::*;

  logic signed [31:0] c0, c1, c2, c3;
  logic signed [63:0] t0_nxt, t1_nxt, t2_nxt, t3_nxt;
  logic signed [63:0] t0_r, t1_r, t2_r, t3_r;
  logic signed [63:0] a_r, b_r, s_r;
  logic signed [63:0] t2b_r, t3b_r, t3c_r;
  logic               ova_r, ovb_r, ovc_r;
  logic [64:0]        a_full, b_full, c_full;

  assign c0 = $signed(row_first[63:32]);
  assign c1 = $signed(row_first[31:0]);
  assign c2 = $signed(row_second[63:32]);
  assign c3 = $signed(row_second[31:0]);

  assign t0_nxt = 64'(c0) * 64'(px);
  assign t1_nxt = 64'(c1) * 64'(py);
  assign t2_nxt = 64'(c2) * 64'(pz);
  assign t3_nxt = 64'(c3) <<< COORD_FRAC_BITS;

  assign a_full = {t0_r[63], t0_r} + {t1_r[63], t1_r};
  assign b_full = {a_r[63], a_r} + {t2b_r[63], t2b_r};
  assign c_full = {b_r[63], b_r} + {t3c_r[63], t3c_r};

  always_ff @(posedge clk) begin
    if (en[0]) begin
      t0_r <= t0_nxt;
      t1_r <= t1_nxt;
      t2_r <= t2_nxt;
      t3_r <= t3_nxt;
    end
    if (en[1]) begin
      a_r   <= $signed(a_full[63:0]);
      ova_r <= a_full[64] ^ a_full[63];
      t2b_r <= t2_r;
      t3b_r <= t3_r;
    end
    if (en[2]) begin
      b_r   <= $signed(b_full[63:0]);
      ovb_r <= ova_r | (b_full[64] ^ b_full[63]);
      t3c_r <= t3b_r;
    end
    if (en[3]) begin
      s_r   <= $signed(c_full[63:0]);
      ovc_r <= ovb_r | (c_full[64] ^ c_full[63]);
    end
  end

  assign sum = s_r;
  assign ov  = ovc_r;

endmodule

// ----- sv/wtsp_div_cell.sv -----
// one quotient bit of the x and y restoring dividers
module wtsp_div_cell (
  input  logic                clk,
  input  logic                en,
  input  wtsp_pkg::div_word_t d_in,
  output wtsp_pkg::div_word_t d_out
);
  import wtsp_pkg::*;

  function automatic div_lane_t lane_step(div_lane_t l, logic [62:0] den);
    logic [63:0] trial;
    logic [64:0] diff;
    div_lane_t   r;
    trial   = {l.rem, l.nbits[6]};
    diff    = {1'b0, trial} - {2'b0, den};
    r.neg   = l.neg;
    r.nbits = {l.nbits[5:0], 1'b0};
    if (!diff[64]) begin
      r.rem = diff[62:0];
      r.quo = {l.quo[QUO_W-2:0], 1'b1};
    end else begin
      r.rem = trial[62:0];
      r.quo = {l.quo[QUO_W-2:0], 1'b0};
    end
    return r;
  endfunction

  div_word_t d_nxt, d_r;

  always_comb begin
    d_nxt    = d_in;
    d_nxt.lx = lane_step(d_in.lx, d_in.den);
    d_nxt.ly = lane_step(d_in.ly, d_in.den);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_r <= d_nxt;
    end
  end

  assign d_out = d_r;

endmodule

// ----- sv/wtsp_pixel.sv -----
// viewport mapping: offset, scale by screen size, truncate, range check
module wtsp_pixel (
  input  logic                clk,
  input  logic [2:0]          en,
  input  wtsp_pkg::div_word_t d_in,
  input  logic [13:0]         screen_width,
  input  logic [13:0]         screen_height,
  output logic [20:0]         pixel_x,
  output logic [20:0]         pixel_y,
  output wtsp_pkg::status_t   status
);
  import wtsp_pkg::*;

  localparam logic signed [41:0] HALF_ONE = 42'sd1 <<< 32;

  logic signed [41:0] qx, qy, ex_nxt, ey_nxt, ex_r, ey_r;
  status_t            sta_r, stb_r, st_nxt, st_r;
  logic signed [56:0] vx_nxt, vy_nxt, vx_r, vy_r;
  logic [56:0]        absx, absy;
  logic [23:0]        mx, my;
  logic [20:0]        px_nxt, py_nxt, px_r, py_r;
  logic               out_of_range;

  assign qx = $signed({3'b0, d_in.lx.quo});
  assign qy = $signed({3'b0, d_in.ly.quo});
  // row axis points down, so y is negated
  assign ex_nxt = HALF_ONE + (d_in.lx.neg ? -qx : qx);
  assign ey_nxt = HALF_ONE + (d_in.ly.neg ? qy : -qy);

  assign vx_nxt = 57'($signed({1'b0, screen_width})) * 57'(ex_r);
  assign vy_nxt = 57'($signed({1'b0, screen_height})) * 57'(ey_r);

  assign absx = vx_r[56] ? 57'(-vx_r) : 57'(vx_r);
  assign absy = vy_r[56] ? 57'(-vy_r) : 57'(vy_r);
  assign mx   = absx[56:33];
  assign my   = absy[56:33];
  assign out_of_range = (mx > 24'(PIX_LIMIT)) || (my > 24'(PIX_LIMIT));

  always_comb begin
    st_nxt = stb_r;
    if (stb_r == ST_OK && out_of_range) begin
      st_nxt = ST_RANGE;
    end
    if (st_nxt == ST_OK) begin
      px_nxt = vx_r[56] ? 21'(-mx) : mx[20:0];
      py_nxt = vy_r[56] ? 21'(-my) : my[20:0];
    end else begin
      px_nxt = '0;
      py_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      ex_r  <= ex_nxt;
      ey_r  <= ey_nxt;
      sta_r <= d_in.st;
    end
    if (en[1]) begin
      vx_r  <= vx_nxt;
      vy_r  <= vy_nxt;
      stb_r <= sta_r;
    end
    if (en[2]) begin
      px_r <= px_nxt;
      py_r <= py_nxt;
      st_r <= st_nxt;
    end
  end

  assign pixel_x = px_r;
  assign pixel_y = py_r;
  assign status  = st_r;

endmodule

// ----- sv/world_to_screen_projection_top.sv -----
// top level of the world-to-screen projection pipeline
//
// input channel: in_valid/in_stall with in_point_x/y/z, signed fixed point
// with COORD_FRAC_BITS fraction bits. result channel: out_valid/out_stall
// with out_pixel_x, out_pixel_y (signed, zero unless status is ok) and
// out_status (0 ok, 1 behind camera, 2 unstable or overflow, 3 out of range).
// config channel: cfg_valid/cfg_ready, cfg_index selects one of eight
// registers, cfg_data carries the value; cfg_ready is always high and
// indexes beyond seven are dropped. write config only while idle.
// throughput: one point per clock while out_stall lets results leave. the
// pipe is made of the input register, the dot product, w classification,
// a row of 39 divider cells (one quotient bit each) and pixel mapping.
// every stage has its own valid bit and moves when the stage after it is
// empty or moving, so bubbles close up behind a stalled result beat and
// new points are taken until the pipe is full.
// reset empties the pipe and restores the matrix to zero and the screen
// to 1920x1080.
module world_to_screen_projection_top #(
  parameter int COORD_FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [31:0] in_point_x,
  input  logic signed [31:0] in_point_y,
  input  logic signed [31:0] in_point_z,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [20:0] out_pixel_x,
  output logic signed [20:0] out_pixel_y,
  output logic [1:0]         out_status,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [3:0]         cfg_index,
  input  logic [63:0]        cfg_data
);
  import wtsp_pkg::*;

  localparam int NST = 7 + QUO_W + 3;
  localparam logic signed [63:0] ONE   = 64'sd1 <<< (16 + COORD_FRAC_BITS);
  localparam logic signed [63:0] W_MIN = (ONE + 64'sd99) / 64'sd100;

  logic [63:0] x0_r, x1_r, y0_r, y1_r, w0_r, w1_r;
  logic [13:0] width_r, height_r;

  logic [NST-1:0] v_r, v_nxt, rdy;

  logic signed [31:0] px_r, py_r, pz_r;
  logic signed [63:0] w_sum, x_sum, y_sum;
  logic               w_ov, x_ov, y_ov;

  status_t     st5_nxt, st5_r;
  logic [63:0] ax_nxt, ay_nxt, ax_r, ay_r;
  logic        nx_r, ny_r;
  logic [62:0] den_r;
  logic [69:0] w100_nxt, w100_r;
  div_word_t   d6_nxt, d6_r;
  div_word_t   chain [0:QUO_W];
  status_t     st_out;

  // config
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x0_r     <= '0;
      x1_r     <= '0;
      y0_r     <= '0;
      y1_r     <= '0;
      w0_r     <= '0;
      w1_r     <= '0;
      width_r  <= 14'd1920;
      height_r <= 14'd1080;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_X_ROW_FIRST:   x0_r     <= cfg_data;
        CFG_X_ROW_SECOND:  x1_r     <= cfg_data;
        CFG_Y_ROW_FIRST:   y0_r     <= cfg_data;
        CFG_Y_ROW_SECOND:  y1_r     <= cfg_data;
        CFG_W_ROW_FIRST:   w0_r     <= cfg_data;
        CFG_W_ROW_SECOND:  w1_r     <= cfg_data;
        CFG_SCREEN_WIDTH:  width_r  <= cfg_data[13:0];
        CFG_SCREEN_HEIGHT: height_r <= cfg_data[13:0];
        default: ;
      endcase
    end
  end

  // per-stage valid and advance chain
  always_comb begin
    rdy[NST-1] = !v_r[NST-1] || !out_stall;
    for (int k = NST - 2; k >= 0; k--) begin
      rdy[k] = !v_r[k] || rdy[k+1];
    end
    v_nxt[0] = rdy[0] ? in_valid : v_r[0];
    for (int k = 1; k < NST; k++) begin
      v_nxt[k] = rdy[k] ? v_r[k-1] : v_r[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  assign in_stall  = !rdy[0];
  assign out_valid = v_r[NST-1];

  // input beat register
  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      px_r <= in_point_x;
      py_r <= in_point_y;
      pz_r <= in_point_z;
    end
  end

  wtsp_dot #(.COORD_FRAC_BITS(COORD_FRAC_BITS)) u_dot_w (
    .clk(clk), .en(rdy[4:1]), .row_first(w0_r), .row_second(w1_r),
    .px(px_r), .py(py_r), .pz(pz_r), .sum(w_sum), .ov(w_ov)
  );

  wtsp_dot #(.COORD_FRAC_BITS(COORD_FRAC_BITS)) u_dot_x (
    .clk(clk), .en(rdy[4:1]), .row_first(x0_r), .row_second(x1_r),
    .px(px_r), .py(py_r), .pz(pz_r), .sum(x_sum), .ov(x_ov)
  );

  wtsp_dot #(.COORD_FRAC_BITS(COORD_FRAC_BITS)) u_dot_y (
    .clk(clk), .en(rdy[4:1]), .row_first(y0_r), .row_second(y1_r),
    .px(px_r), .py(py_r), .pz(pz_r), .sum(y_sum), .ov(y_ov)
  );

  // w classification, magnitudes, 100*w
  always_comb begin
    if (w_ov) begin
      st5_nxt = ST_UNSTABLE;
    end else if (w_sum < W_MIN) begin
      st5_nxt = ST_BEHIND;
    end else if (x_ov || y_ov) begin
      st5_nxt = ST_UNSTABLE;
    end else begin
      st5_nxt = ST_OK;
    end
    ax_nxt   = x_sum[63] ? 64'(-x_sum) : 64'(x_sum);
    ay_nxt   = y_sum[63] ? 64'(-y_sum) : 64'(y_sum);
    w100_nxt = ({7'b0, w_sum[62:0]} << 6) + ({7'b0, w_sum[62:0]} << 5)
             + ({7'b0, w_sum[62:0]} << 2);
  end

  always_ff @(posedge clk) begin
    if (rdy[5]) begin
      st5_r  <= st5_nxt;
      ax_r   <= ax_nxt;
      ay_r   <= ay_nxt;
      nx_r   <= x_sum[63];
      ny_r   <= y_sum[63];
      den_r  <= w_sum[62:0];
      w100_r <= w100_nxt;
    end
  end

  // magnitude bound and divider seed: remainder starts at |num| >> 7
  always_comb begin
    d6_nxt          = '0;
    d6_nxt.den      = den_r;
    d6_nxt.lx.rem   = {6'b0, ax_r[63:7]};
    d6_nxt.lx.nbits = ax_r[6:0];
    d6_nxt.lx.neg   = nx_r;
    d6_nxt.ly.rem   = {6'b0, ay_r[63:7]};
    d6_nxt.ly.nbits = ay_r[6:0];
    d6_nxt.ly.neg   = ny_r;
    d6_nxt.st       = st5_r;
    if (st5_r == ST_OK && (({6'b0, ax_r} > w100_r) || ({6'b0, ay_r} > w100_r))) begin
      d6_nxt.st = ST_UNSTABLE;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[6]) begin
      d6_r <= d6_nxt;
    end
  end

  assign chain[0] = d6_r;

  for (genvar gi = 0; gi < QUO_W; gi++) begin : g_cell
    wtsp_div_cell u_cell (
      .clk(clk), .en(rdy[7+gi]), .d_in(chain[gi]), .d_out(chain[gi+1])
    );
  end

  wtsp_pixel u_pixel (
    .clk(clk), .en(rdy[NST-1:NST-3]), .d_in(chain[QUO_W]),
    .screen_width(width_r), .screen_height(height_r),
    .pixel_x(out_pixel_x), .pixel_y(out_pixel_y), .status(st_out)
  );

  assign out_status = st_out;

endmodule

// ----- tb/testbench.sv -----
// self-checking testbench for the world-to-screen projection pipeline
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import wtsp_pkg::*;

  localparam int FRAC = 16;
  localparam int LATENCY = 48;
  localparam longint CYCLE_LIMIT = 1000000;
  localparam int N_RANDOM = 1800;

  typedef struct {
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] pz;
  } point_t;

  typedef struct {
    logic signed [20:0] col;
    logic signed [20:0] row;
    status_t            st;
  } pixel_t;

  logic clk = 0;
  logic rst_n = 0;
  logic in_valid = 0;
  logic in_stall;
  logic signed [31:0] in_point_x = 0, in_point_y = 0, in_point_z = 0;
  logic out_valid;
  logic out_stall = 0;
  logic signed [20:0] out_pixel_x, out_pixel_y;
  logic [1:0] out_status;
  logic cfg_valid = 0;
  logic cfg_ready;
  logic [3:0] cfg_index = 0;
  logic [63:0] cfg_data = 0;

  world_to_screen_projection_top #(.COORD_FRAC_BITS(FRAC)) dut (.*);

  always #5 clk = ~clk;

  // matrix and screen shadow registers
  logic [63:0] mat_reg [6];
  logic [13:0] scr_w, scr_h;

  point_t pending_points[$];
  pixel_t expected_pixels[$];
  int     errors = 0;
  longint cycles = 0;
  int     beats_out = 0;
  int     hold_cycles = 0;
  bit     drive_on = 0;
  bit     stall_on = 0;

  function automatic logic signed [63:0] coef(logic [63:0] r, bit upper);
    return upper ? 64'(signed'(r[63:32])) : 64'(signed'(r[31:0]));
  endfunction

  // row dot product, overflow sets ov
  function automatic logic signed [63:0] row_dot(logic [63:0] a, logic [63:0] b,
                                                 point_t p, inout bit ov);
    logic signed [127:0] s;
    logic signed [127:0] terms [3];
    terms[0] = 128'(coef(a, 0)) * 128'(p.py);
    terms[1] = 128'(coef(b, 1)) * 128'(p.pz);
    terms[2] = 128'(coef(b, 0)) * (128'sd1 <<< FRAC);
    s = 128'(coef(a, 1)) * 128'(p.px);
    for (int i = 0; i < 3; i++) begin
      s = s + terms[i];
      if (s > 128'sh7FFF_FFFF_FFFF_FFFF || s < -128'sh8000_0000_0000_0000) begin
        ov = 1;
        s = 0;
      end
    end
    return s[63:0];
  endfunction

  function automatic bit div_frac(logic signed [63:0] num, logic [63:0] den,
                                  output logic signed [63:0] q);
    logic [63:0] a, ip, r;
    logic [31:0] f;
    a = num < 0 ? -num : num;
    ip = a / den;
    r = a % den;
    q = 0;
    if (ip > 100 || (ip == 100 && r != 0)) return 0;
    f = 0;
    for (int i = 0; i < 32; i++) begin
      r = r << 1;
      f = f << 1;
      if (r >= den) begin
        r = r - den;
        f[0] = 1;
      end
    end
    q = (ip << 32) | f;
    if (num < 0) q = -q;
    return 1;
  endfunction

  function automatic logic signed [63:0] pix_map(logic [13:0] size, logic signed [63:0] n);
    logic signed [127:0] v, m;
    v = 128'(signed'({1'b0, size})) * ((128'sd1 <<< 32) + 128'(n));
    m = (v < 0 ? -v : v) >>> 33;
    return v < 0 ? -m[63:0] : m[63:0];
  endfunction

  function automatic pixel_t project(point_t p);
    pixel_t res;
    bit ov;
    logic signed [63:0] w, x, y, qx, qy, cx, cy;
    logic signed [63:0] one;
    one = 64'sd1 <<< (16 + FRAC);
    ov = 0;
    cx = 0;
    cy = 0;
    res.st = ST_OK;
    w = row_dot(mat_reg[4], mat_reg[5], p, ov);
    if (ov) res.st = ST_UNSTABLE;
    else if (w <= 0 || (w < one && w * 100 < one)) res.st = ST_BEHIND;
    else begin
      x = row_dot(mat_reg[0], mat_reg[1], p, ov);
      y = row_dot(mat_reg[2], mat_reg[3], p, ov);
      if (ov || !div_frac(x, w, qx) || !div_frac(y, w, qy)) res.st = ST_UNSTABLE;
      else begin
        cx = pix_map(scr_w, qx);
        cy = pix_map(scr_h, -qy);
        if (cx > PIX_LIMIT || cx < -PIX_LIMIT || cy > PIX_LIMIT || cy < -PIX_LIMIT)
          res.st = ST_RANGE;
      end
    end
    if (res.st != ST_OK) begin
      cx = 0;
      cy = 0;
    end
    res.col = cx[20:0];
    res.row = cy[20:0];
    return res;
  endfunction

  function automatic int gap_len();
    return ($urandom_range(0, 19) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 3);
  endfunction

  // stall as sampled at the rising edge, tells the driver whether its beat left
  logic in_stall_q = 0;
  always @(posedge clk) in_stall_q <= in_stall;

  // driver: one beat per accepting edge, gaps between beats while stall_on is set
  int gap_left = 0;
  always @(negedge clk) begin
    if (!(in_valid && in_stall_q)) begin
      if (gap_left > 0 || !drive_on || pending_points.size() == 0) begin
        in_valid <= 0;
        if (gap_left > 0) gap_left <= gap_left - 1;
      end else begin
        point_t p;
        p = pending_points.pop_front();
        expected_pixels.push_back(project(p));
        in_point_x <= p.px;
        in_point_y <= p.py;
        in_point_z <= p.pz;
        in_valid <= 1;
        gap_left <= stall_on ? gap_len() : 0;
      end
    end
  end

  // receiver stall pattern and the long hold-off
  int stall_left = 0;
  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      out_stall <= 1;
      hold_cycles <= hold_cycles - 1;
    end else if (!stall_on) out_stall <= 0;
    else if (stall_left > 0) begin
      out_stall <= 1;
      stall_left <= stall_left - 1;
    end else begin
      out_stall <= 0;
      if ($urandom_range(0, 3) == 0) stall_left <= gap_len();
    end
  end

  // monitor
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (rst_n && out_valid && !out_stall) begin
      beats_out <= beats_out + 1;
      if (expected_pixels.size() == 0) begin
        $error("result beat with nothing expected");
        errors = errors + 1;
      end else begin
        pixel_t e;
        e = expected_pixels.pop_front();
        if (out_pixel_x !== e.col) begin
          $error("pixel_x expected %0d got %0d", e.col, out_pixel_x);
          errors = errors + 1;
        end
        if (out_pixel_y !== e.row) begin
          $error("pixel_y expected %0d got %0d", e.row, out_pixel_y);
          errors = errors + 1;
        end
        if (out_status !== e.st) begin
          $error("status expected %0d got %0d", e.st, out_status);
          errors = errors + 1;
        end
      end
    end
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("end of test: mismatches");
      $finish;
    end
  end

  task automatic write_reg(logic [3:0] idx, logic [63:0] val);
    @(negedge clk);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 0;
    if (idx <= CFG_W_ROW_SECOND) mat_reg[idx[2:0]] = val;
    else if (idx == CFG_SCREEN_WIDTH) scr_w = val[13:0];
    else if (idx == CFG_SCREEN_HEIGHT) scr_h = val[13:0];
  endtask

  task automatic drain();
    while (pending_points.size() != 0 || in_valid || expected_pixels.size() != 0)
      @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  function automatic logic [31:0] q16(int v);
    return 32'(v) << 16;
  endfunction

  // perspective-like matrix, with small random perturbation when noisy
  task automatic load_camera(bit noisy, logic [13:0] w, logic [13:0] h);
    logic [31:0] jit [8];
    for (int i = 0; i < 8; i++)
      jit[i] = noisy ? 32'($urandom_range(0, 32'h3FFFF)) - 32'h1FFFF : 0;
    write_reg(CFG_X_ROW_FIRST,   {q16(1) + jit[0], jit[1]});
    write_reg(CFG_X_ROW_SECOND,  {jit[2], jit[3]});
    write_reg(CFG_Y_ROW_FIRST,   {jit[4], q16(1) + jit[5]});
    write_reg(CFG_Y_ROW_SECOND,  {jit[6], jit[7]});
    write_reg(CFG_W_ROW_FIRST,   64'd0);
    write_reg(CFG_W_ROW_SECOND,  {q16(1), q16(0)});
    write_reg(CFG_SCREEN_WIDTH,  64'(w));
    write_reg(CFG_SCREEN_HEIGHT, 64'(h));
  endtask

  function automatic point_t mk(logic [31:0] x, logic [31:0] y, logic [31:0] z);
    point_t p;
    p.px = x;
    p.py = y;
    p.pz = z;
    return p;
  endfunction

  // mostly points in front of the camera within the frustum, some wild
  function automatic point_t rand_point();
    case ($urandom_range(0, 9))
      0, 1: return mk($urandom, $urandom, $urandom);
      2: return mk($urandom, $urandom, $urandom_range(0, 32'h400));
      default: begin
        int z;
        z = $urandom_range(32'h100, 32'h7FFFFF);
        return mk(32'($urandom_range(0, 2 * z)) - z, 32'($urandom_range(0, 2 * z)) - z,
                  z);
      end
    endcase
  endfunction

  initial begin
    for (int i = 0; i < 6; i++) mat_reg[i] = 0;
    scr_w = 1920;
    scr_h = 1080;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1;

    // reset matrix: w is zero so everything lies behind the camera
    pending_points.push_back(mk(q16(1), q16(1), q16(1)));
    drive_on = 1;
    drain();

    // directed: identity-like camera, extremes, behind and unstable rejections
    load_camera(0, 1920, 1080);
    pending_points.push_back(mk(0, 0, q16(1)));
    pending_points.push_back(mk(q16(1), q16(-1), q16(1)));
    pending_points.push_back(mk(q16(-1), q16(1), q16(1)));
    pending_points.push_back(mk(q16(1), q16(1), -q16(1)));
    pending_points.push_back(mk(0, 0, 0));
    pending_points.push_back(mk(0, 0, 655));
    pending_points.push_back(mk(0, 0, 656));
    pending_points.push_back(mk(q16(100), 0, q16(1)));
    pending_points.push_back(mk(q16(100) + 1, 0, q16(1)));
    pending_points.push_back(mk(0, -q16(100) - 1, q16(1)));
    pending_points.push_back(mk(32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF));
    pending_points.push_back(mk(32'h80000000, 32'h7FFFFFFF, 32'h80000000));
    pending_points.push_back(mk(32'hFFFFFFFF, 32'hFFFFFFFF, 32'h7FFFFFFF));
    drain();

    // overflow: huge coefficients in the w rows and the first x row
    write_reg(CFG_W_ROW_FIRST, 64'h7FFFFFFF_80000000);
    write_reg(CFG_W_ROW_SECOND, 64'h7FFFFFFF_7FFFFFFF);
    write_reg(CFG_X_ROW_FIRST, 64'h80000000_80000000);
    pending_points.push_back(mk(32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF));
    pending_points.push_back(mk(32'h80000000, 32'h80000000, 32'h80000000));
    pending_points.push_back(mk(q16(1), 0, q16(1)));
    pending_points.push_back(mk(0, 0, 1));
    drain();
    // extreme and zero screen sizes
    load_camera(0, 14'h3FFF, 0);
    pending_points.push_back(mk(q16(1), q16(1), q16(1)));
    pending_points.push_back(mk(-q16(99), q16(99), q16(1)));
    drain();
    load_camera(0, 1, 8192);
    pending_points.push_back(mk(q16(1), -q16(1), q16(2)));
    pending_points.push_back(mk(3, -5, q16(3)));
    drain();
    write_reg(4'd9, 64'hFFFF);  // out of range index, dropped

    // random phases with differing cameras and sizes
    stall_on = 1;
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: load_camera(1, 1920, 1080);
        1: load_camera(1, 8192, 8192);
        2: load_camera(1, 1, 1);
        default: load_camera(1, 14'($urandom_range(1, 8192)), 14'($urandom_range(1, 8192)));
      endcase
      if (ph == 5) begin
        for (int i = 0; i < 6; i++) write_reg(4'(i), {$urandom, $urandom});
      end
      for (int i = 0; i < N_RANDOM / 6; i++) pending_points.push_back(rand_point());
      if (ph == 1) begin
        stall_on = 0;
        @(negedge clk);
        hold_cycles = 300;
        wait (hold_cycles == 0);
        stall_on = 1;
      end
      drain();
    end

    $display("covered directed extremes, rejection cases and %0d random points", N_RANDOM);
    $display("%0d result beats checked over %0d cycles", beats_out, cycles);
    if (errors == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end
endmodule

// ----- files.f -----
sv/wtsp_pkg.sv
sv/wtsp_dot.sv
sv/wtsp_div_cell.sv
sv/wtsp_pixel.sv
sv/world_to_screen_projection_top.sv
tb/testbench.sv
